/* rtl/okse_pkg.sv */
// Shared types and constants for the ordered key set with bulk eviction.
// Depends on nothing; the interfaces and the top level import it.

package okse_pkg;

   // Field widths of the request and response transfers.
   localparam int OP_W    = 3;
   localparam int KEY_W   = 32;
   localparam int EVICT_W = 8;
   localparam int COUNT_W = 11;

   // A full set drops the oldest 1/EVICT_DIV of its keys before a new mark.
   localparam int EVICT_DIV = 8;

   // Operation codes; the codes above commit behave as a query.
   typedef enum logic [OP_W-1:0] {
      OP_QUERY   = 3'd0,
      OP_MARK    = 3'd1,
      OP_UNMARK  = 3'd2,
      OP_PRELOAD = 3'd3,
      OP_COMMIT  = 3'd4
   } okse_op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_APPEND,
      ST_DONE
   } okse_state_type;

endpackage

/* rtl/okse_if.sv */
// Valid/ready channel interfaces for the request and response transfers.
// Depends on okse_pkg for the field widths.

interface okse_req_if
   import okse_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [KEY_W-1:0]   key;
   logic               link_empty;

   modport source (output valid, op, key, link_empty, input ready);
   modport sink   (input valid, op, key, link_empty, output ready);
endinterface

interface okse_rsp_if
   import okse_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               was_member;
   logic               changed;
   logic [EVICT_W-1:0] evicted;
   logic [COUNT_W-1:0] entry_count;
   logic               dirty;

   modport source (output valid, was_member, changed, evicted, entry_count, dirty,
                   input ready);
   modport sink   (input valid, was_member, changed, evicted, entry_count, dirty,
                   output ready);
endinterface

/* rtl/ordered_key_set_bulk_evict.sv */
// Ordered key set: empty, commit and preload requests go straight to the final state. A
// lookup reads the keys in order, oldest first, until a hit or the end; a move that closes a
// gap or drops the oldest eighth copies the keys down one by one, and an append writes the
// new key at the end. The key memory takes one read and one write per cycle; requests are
// handled one at a time, and a finished response waits while the output stalls.
// Synchronous reset clears the count, dirty flag, sequencer and response; keys are kept.

module ordered_key_set_bulk_evict
   import okse_pkg::*;
   #(
   parameter int CAPACITY = 1024
   ) (
   input  logic        clock,
   input  logic        reset,
   okse_req_if.sink    req_bus,
   okse_rsp_if.source  rsp_bus
   );

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [CW-1:0]      CAP_C     = CW'(CAPACITY);
   localparam logic [CW-1:0]      EVICT_C   = CW'(CAPACITY / EVICT_DIV);
   localparam logic [CW-1:0]      KEEP_C    = CW'(CAPACITY - CAPACITY / EVICT_DIV);
   localparam logic [EVICT_W-1:0] EVICT_OUT = EVICT_W'(CAPACITY / EVICT_DIV);

   // Key memory, oldest key at address zero.
   logic [KEY_W-1:0] mem [CAPACITY];
   logic [KEY_W-1:0] rdata_ff;
   logic [AW-1:0]    rd_addr;
   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   logic [KEY_W-1:0] mem_wd;

   // Sequencer and set state.
   okse_state_type     state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CW-1:0]      total_ff, total_in;
   logic               dirty_ff, dirty_in;
   logic [CW-1:0]      src_ff, src_in;
   logic [CW-1:0]      dst_ff, dst_in;
   logic [CW-1:0]      end_ff, end_in;
   logic               pend_ff, pend_in;
   logic [CW-1:0]      pend_addr_ff, pend_addr_in;
   logic               member_ff, member_in;
   logic               changed_ff, changed_in;
   logic               evict_ff, evict_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_member_ff, rsp_member_in;
   logic               rsp_changed_ff, rsp_changed_in;
   logic [EVICT_W-1:0] rsp_evicted_ff, rsp_evicted_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_dirty_ff, rsp_dirty_in;

   logic issue;
   logic hit;

   // The memory is written at one address and read at one address per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Next state and memory control.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      total_in       = total_ff;
      dirty_in       = dirty_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      end_in         = end_ff;
      pend_in        = pend_ff;
      pend_addr_in   = pend_addr_ff;
      member_in      = member_ff;
      changed_in     = changed_ff;
      evict_in       = evict_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_member_in  = rsp_member_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_dirty_in   = rsp_dirty_ff;
      mem_we         = 1'b0;
      mem_wa         = total_ff[AW-1:0];
      mem_wd         = key_ff;
      rd_addr        = src_ff[AW-1:0];
      req_bus.ready  = 1'b0;
      issue          = 1'b0;
      hit            = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               op_in      = req_bus.op;
               key_in     = req_bus.key;
               member_in  = 1'b0;
               changed_in = 1'b0;
               evict_in   = 1'b0;
               if (req_bus.link_empty) begin
                  state_in = ST_DONE;
               end else begin
                  unique case (req_bus.op)
                     OP_PRELOAD: begin
                        // Append without lookup; ignored on a full set.
                        if (total_ff < CAP_C) begin
                           mem_we     = 1'b1;
                           mem_wd     = req_bus.key;
                           total_in   = total_ff + 1'b1;
                           changed_in = 1'b1;
                        end
                        state_in = ST_DONE;
                     end
                     OP_COMMIT: begin
                        dirty_in = 1'b0;
                        state_in = ST_DONE;
                     end
                     default: begin
                        src_in   = '0;
                        pend_in  = 1'b0;
                        state_in = ST_SCAN;
                     end
                  endcase
               end
            end
         end

         ST_SCAN: begin
            // One read issued per cycle; its data is compared in the next cycle.
            hit   = pend_ff && (rdata_ff == key_ff);
            issue = (src_ff < total_ff);
            if (issue) begin
               src_in = src_ff + 1'b1;
            end
            pend_in      = issue && !hit;
            pend_addr_in = src_ff;
            if (hit || (!issue && !pend_ff)) begin
               member_in = hit;
               pend_in   = 1'b0;
               if (op_ff == OP_MARK && !hit) begin
                  if (total_ff >= CAP_C) begin
                     // Drop the oldest eighth by moving the rest down.
                     src_in   = EVICT_C;
                     dst_in   = '0;
                     end_in   = CAP_C;
                     evict_in = 1'b1;
                     state_in = ST_SHIFT;
                  end else begin
                     state_in = ST_APPEND;
                  end
               end else if (op_ff == OP_UNMARK && hit) begin
                  // Close the gap left by the removed key.
                  src_in   = pend_addr_ff + 1'b1;
                  dst_in   = pend_addr_ff;
                  end_in   = total_ff;
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_SHIFT: begin
            // Read at the source pointer, write the returned word in the cycle after.
            issue = (src_ff < end_ff);
            if (issue) begin
               src_in = src_ff + 1'b1;
            end
            pend_in = issue;
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_wa = dst_ff[AW-1:0];
               mem_wd = rdata_ff;
               dst_in = dst_ff + 1'b1;
            end
            if (!issue && !pend_ff) begin
               if (op_ff == OP_MARK) begin
                  total_in = KEEP_C;
                  state_in = ST_APPEND;
               end else begin
                  total_in   = total_ff - 1'b1;
                  dirty_in   = 1'b1;
                  changed_in = 1'b1;
                  state_in   = ST_DONE;
               end
            end
         end

         ST_APPEND: begin
            mem_we     = 1'b1;
            total_in   = total_ff + 1'b1;
            dirty_in   = 1'b1;
            changed_in = 1'b1;
            state_in   = ST_DONE;
         end

         ST_DONE: begin
            // Load the response register once it is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_member_in  = member_ff;
               rsp_changed_in = changed_ff;
               rsp_evicted_in = evict_ff ? EVICT_OUT : '0;
               rsp_count_in   = COUNT_W'(total_ff);
               rsp_dirty_in   = dirty_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         dirty_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         dirty_ff     <= dirty_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      src_ff         <= src_in;
      dst_ff         <= dst_in;
      end_ff         <= end_in;
      pend_addr_ff   <= pend_addr_in;
      member_ff      <= member_in;
      changed_ff     <= changed_in;
      evict_ff       <= evict_in;
      rsp_member_ff  <= rsp_member_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_dirty_ff   <= rsp_dirty_in;
   end

   // Response outputs.
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.was_member  = rsp_member_ff;
   assign rsp_bus.changed     = rsp_changed_ff;
   assign rsp_bus.evicted     = rsp_evicted_ff;
   assign rsp_bus.entry_count = rsp_count_ff;
   assign rsp_bus.dirty       = rsp_dirty_ff;

   // The stored count never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset) total_ff <= CAP_C)
      else $error("key count exceeds capacity");

   // A move writes only below the next address to be read.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && mem_we) |-> (dst_ff < src_ff))
      else $error("shift writes ahead of its read pointer");

   // A new response is only ever loaded from the final state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the final state");

   // An accepted empty-link request finishes without touching the store.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_bus.valid && req_bus.link_empty)
         |=> (state_ff == ST_DONE && $stable(total_ff)))
      else $error("empty-link request did not complete directly");

endmodule

/* tb/sv/okse_tb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the ordered key set: it mirrors the set and predicts each response.
// Depends on okse_pkg for the field widths and operation codes.

package okse_tb_pkg;
   import okse_pkg::*;

   // One predicted response, with fields in the same order as the response transfer.
   typedef struct packed {
      logic               was_member;
      logic               changed;
      logic [EVICT_W-1:0] evicted;
      logic [COUNT_W-1:0] entry_count;
      logic               dirty;
   } set_outcome_type;

   class key_set_scoreboard;
      int               capacity;
      int               failures;
      int               results_seen;
      logic [KEY_W-1:0] held_keys[$];
      logic             dirty;
      set_outcome_type  pending_outcomes[$];

      function new(int cap);
         capacity     = cap;
         failures     = 0;
         results_seen = 0;
         dirty        = 1'b0;
      endfunction

      function int held_count();
         return held_keys.size();
      endfunction

      function logic [KEY_W-1:0] held_key(int idx);
         return held_keys[idx];
      endfunction

      function int pending();
         return pending_outcomes.size();
      endfunction

      // Position of the oldest copy of a key, or -1 when the key is absent.
      function int find_oldest(logic [KEY_W-1:0] k);
         for (int i = 0; i < held_keys.size(); i++) begin
            if (held_keys[i] == k) begin
               return i;
            end
         end
         return -1;
      endfunction

      // Applies one request to the mirrored set and returns the response it should cause.
      function set_outcome_type predict_outcome(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                                logic empty);
         set_outcome_type res;
         int              at;
         res = '0;
         if (!empty) begin
            if (op == OP_PRELOAD) begin
               // Preload skips the lookup and is dropped once the set is full.
               if (held_keys.size() < capacity) begin
                  held_keys.push_back(k);
                  res.changed = 1'b1;
               end
            end else if (op == OP_COMMIT) begin
               dirty = 1'b0;
            end else begin
               // Query, mark, unmark and the reserved codes all look the key up first.
               at = find_oldest(k);
               res.was_member = (at >= 0);
               if (op == OP_MARK && at < 0) begin
                  if (held_keys.size() >= capacity) begin
                     repeat (capacity / EVICT_DIV) void'(held_keys.pop_front());
                     res.evicted = EVICT_W'(capacity / EVICT_DIV);
                  end
                  held_keys.push_back(k);
                  dirty       = 1'b1;
                  res.changed = 1'b1;
               end else if (op == OP_UNMARK && at >= 0) begin
                  held_keys.delete(at);
                  dirty       = 1'b1;
                  res.changed = 1'b1;
               end
            end
         end
         res.entry_count = COUNT_W'(held_keys.size());
         res.dirty       = dirty;
         return res;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic empty);
         pending_outcomes.push_back(predict_outcome(op, k, empty));
      endfunction

      // Only the first ten problems are printed; the rest are counted.
      function void flag(string msg);
         failures++;
         if (failures <= 10) begin
            $display("[%0t] response %0d: %s", $time, results_seen, msg);
         end
      endfunction

      function void compare_field(string name, logic [COUNT_W-1:0] want,
                                  logic [COUNT_W-1:0] got);
         if (got !== want) begin
            flag($sformatf("%s expected %0d, got %0d", name, want, got));
         end
      endfunction

      function void check_outcome(set_outcome_type got);
         set_outcome_type want;
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            flag("response with no request outstanding");
            return;
         end
         want = pending_outcomes.pop_front();
         compare_field("was_member", COUNT_W'(want.was_member), COUNT_W'(got.was_member));
         compare_field("changed", COUNT_W'(want.changed), COUNT_W'(got.changed));
         compare_field("evicted", COUNT_W'(want.evicted), COUNT_W'(got.evicted));
         compare_field("entry_count", want.entry_count, got.entry_count);
         compare_field("dirty", COUNT_W'(want.dirty), COUNT_W'(got.dirty));
      endfunction
   endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Top-level testbench for ordered_key_set_bulk_evict: drives requests, stalls responses.
// Depends on okse_pkg, the okse_req_if/okse_rsp_if interfaces and okse_tb_pkg.

module tb_top;
   import okse_pkg::*;
   import okse_tb_pkg::*;

   localparam int CAPACITY     = 1024;
   localparam int MAX_WAIT     = 16;
   localparam int ITEM_CYCLES  = 2 * CAPACITY + 8;
   localparam int WATCH_LIMIT  = 8 * (ITEM_CYCLES + 2 * MAX_WAIT);
   localparam int RANDOM_ITEMS = 553;
   localparam int SMALL_LIMIT  = 48;
   localparam int POOL_SIZE    = 24;

   // Codes above commit are reserved and behave as a query.
   localparam logic [OP_W-1:0] OP_RSVD_FIRST = OP_W'(OP_COMMIT + 1);
   localparam logic [OP_W-1:0] OP_RSVD_LAST  = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   okse_req_if req_bus ();
   okse_rsp_if rsp_bus ();

   ordered_key_set_bulk_evict #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   key_set_scoreboard sb;
   logic [KEY_W-1:0]  key_pool [POOL_SIZE];
   int                send_calm   = 0;
   int                quiet_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Wait draw per transfer; now and then a run of back-to-back transfers.
   function automatic int pick_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // Keys come from the held set, a small shared pool, or fresh random values.
   function automatic logic [KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sb.held_count() > 0 && sel < 4) begin
         return sb.held_key($urandom_range(0, sb.held_count() - 1));
      end
      if (sel < 8) begin
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      return $urandom();
   endfunction

   // Presents one request and returns at the edge where it is transferred.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                               input logic empty);
      int gap;
      gap = pick_wait(send_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.key        <= k;
      req_bus.link_empty <= empty;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(op, k, empty);
   endtask

   // One random request; in small mode a large set is trimmed back with unmarks.
   task automatic send_mixed(input bit keep_small);
      int               pick;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] k;
      logic             empty;
      pick  = $urandom_range(0, 99);
      empty = ($urandom_range(0, 19) == 0);
      k     = pick_key();
      if (keep_small && sb.held_count() >= SMALL_LIMIT) begin
         op = OP_UNMARK;
         k  = sb.held_key($urandom_range(0, sb.held_count() - 1));
      end else if (pick < 25) begin
         op = OP_QUERY;
      end else if (pick < 55) begin
         op = OP_MARK;
      end else if (pick < 75) begin
         op = OP_UNMARK;
      end else if (pick < 85) begin
         op = OP_PRELOAD;
      end else if (pick < 92) begin
         op = OP_COMMIT;
      end else begin
         op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      end
      send_request(op, k, empty);
   endtask

   // Response side: after each transfer, hold ready low for a drawn number of cycles
   // counted from when a response shows up.
   initial begin
      int wait_n;
      int calm;
      calm = 0;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         wait_n = pick_wait(calm);
         if (wait_n > 0) begin
            rsp_bus.ready <= 1'b0;
            do @(posedge clock); while (!rsp_bus.valid);
            repeat (wait_n - 1) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Checks every response transfer and stops the run if nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_outcome({rsp_bus.was_member, rsp_bus.changed, rsp_bus.evicted,
                              rsp_bus.entry_count, rsp_bus.dirty});
         end
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready)) begin
            quiet_cycles = 0;
         end else if (quiet_cycles >= WATCH_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end else begin
            quiet_cycles = quiet_cycles + 1;
         end
      end
   end

   // Request side: directed cases, then a long random stretch on a small set.
   initial begin
      sb = new(CAPACITY);
      req_bus.valid      <= 1'b0;
      req_bus.op         <= OP_QUERY;
      req_bus.key        <= '0;
      req_bus.link_empty <= 1'b0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom();
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Empty set: misses, then the lowest and highest keys.
      send_request(OP_QUERY, 32'h0000_0000, 1'b0);
      send_request(OP_UNMARK, 32'h0000_0000, 1'b0);
      send_request(OP_MARK, 32'h0000_0000, 1'b0);
      send_request(OP_MARK, 32'hFFFF_FFFF, 1'b0);
      send_request(OP_MARK, 32'h0000_0000, 1'b0);
      send_request(OP_QUERY, 32'hFFFF_FFFF, 1'b0);
      // A preloaded duplicate survives an unmark of the oldest copy.
      send_request(OP_PRELOAD, 32'hFFFF_FFFF, 1'b0);
      send_request(OP_UNMARK, 32'hFFFF_FFFF, 1'b0);
      send_request(OP_QUERY, 32'hFFFF_FFFF, 1'b0);
      // Commit clears dirty; a later preload leaves it clear.
      send_request(OP_COMMIT, 32'h0000_0000, 1'b0);
      send_request(OP_PRELOAD, 32'h5A5A_5A5A, 1'b0);
      send_request(OP_COMMIT, 32'h5A5A_5A5A, 1'b0);
      // Items with an empty link leave everything alone.
      send_request(OP_MARK, 32'hA5A5_A5A5, 1'b1);
      send_request(OP_UNMARK, 32'h0000_0000, 1'b1);
      send_request(OP_PRELOAD, 32'h1234_5678, 1'b1);
      send_request(OP_QUERY, 32'hFFFF_FFFF, 1'b1);
      // Reserved codes act as lookups, hit and miss.
      for (int c = OP_RSVD_FIRST; c <= OP_RSVD_LAST; c++) begin
         send_request(OP_W'(c), 32'h0000_0000, 1'b0);
         send_request(OP_W'(c), 32'h1234_5678, 1'b0);
      end
      // Unmarks at the head and the tail of the order.
      send_request(OP_UNMARK, 32'h0000_0000, 1'b0);
      send_request(OP_UNMARK, 32'h5A5A_5A5A, 1'b0);
      send_request(OP_COMMIT, 32'h0000_0000, 1'b1);
      send_request(OP_COMMIT, 32'h0000_0000, 1'b0);

      // Random traffic with the set kept small so each lookup stays short.
      repeat (RANDOM_ITEMS) send_mixed(1'b1);
      send_request(OP_COMMIT, $urandom(), 1'b0);
      req_bus.valid <= 1'b0;

      // Drain outstanding responses, then give the block time to misbehave.
      while (sb.pending() > 0) @(posedge clock);
      repeat (ITEM_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
